/* hdl/hvt_pkg.sv */
// Package for the hierarchical vertex transform core: table sizes, address
// widths, fixed-point constants and the control struct of the shared MAC.
// No dependencies.
`default_nettype none

package hvt_pkg;

  localparam int MAX_OBJECTS = 32;
  localparam int OBJ_W       = 5;
  localparam int WORD_W      = 16;
  localparam int DEPTH_W     = 5;
  localparam int FRAC_BITS   = 12;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int QUOT_W      = PROD_W - FRAC_BITS;
  localparam int ACC_W       = QUOT_W + 2;

  localparam int MAT_DEPTH = MAX_OBJECTS * 9;
  localparam int TRN_DEPTH = MAX_OBJECTS * 3;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int TRN_AW    = $clog2(TRN_DEPTH);
  localparam int DEP_AW    = $clog2(MAX_OBJECTS);

  localparam logic [3:0] SEL_TRN_X = 4'd9;
  localparam logic [3:0] SEL_DEPTH = 4'd12;

  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSFORM = 1'b1;

  typedef struct packed {
    logic mul;   // register the product of the two operands
    logic acc;   // add the truncated quotient into the accumulator
    logic clr;   // start a new row sum instead of adding
  } mac_ctl_t;

endpackage

`default_nettype wire

/* hdl/hierarchical_vertex_transform_core.sv */
// Top level of the hierarchical vertex transform core: object tables,
// sequencer, parent search and output register. Depends on hvt_pkg, hvt_mac.
`default_nettype none

// The core holds, for each of 32 objects, a 3x3 matrix in 4.12 fixed point,
// a translation and a skeleton depth, all loaded by table-write transfers
// (kind 0). A transform transfer (kind 1) runs the vertex through the
// object's matrix and translation and then through each parent up to the
// root, where the parent of an object is the nearest lower-indexed object
// whose depth is exactly one less. On each level the nine matrix elements
// pass one at a time through the single shared multiplier (memory read,
// multiply, scale and accumulate), the translation is added to each row
// sum, and the depth of the object is read. The parent search then reads
// the depth table one entry at a time, going downward from the current
// object. If no parent is found the result carries zero coordinates with
// parent_missing set. The input is not ready while a transform is in
// progress; one finished result may wait in the output register while the
// next transfer is taken. Every table entry must be written before a
// transform reads it.
module hierarchical_vertex_transform_core
  import hvt_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [0:0]               kind,
  input  wire  [OBJ_W-1:0]         object_index,
  input  wire  [3:0]               word_select,
  input  wire  signed [WORD_W-1:0] word_value,
  input  wire  signed [WORD_W-1:0] vertex_x,
  input  wire  signed [WORD_W-1:0] vertex_y,
  input  wire  signed [WORD_W-1:0] vertex_z,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [WORD_W-1:0] out_x,
  output logic signed [WORD_W-1:0] out_y,
  output logic signed [WORD_W-1:0] out_z,
  output logic                     parent_missing
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MWAIT = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_ACC   = 10'b00_0000_1000,
    S_ROW   = 10'b00_0001_0000,
    S_DREAD = 10'b00_0010_0000,
    S_DCHK  = 10'b00_0100_0000,
    S_SREAD = 10'b00_1000_0000,
    S_SCHK  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Table memories; reads are registered every cycle.
  logic signed [WORD_W-1:0]  mat_mem [MAT_DEPTH];
  logic signed [WORD_W-1:0]  trn_mem [TRN_DEPTH];
  logic        [DEPTH_W-1:0] dep_mem [MAX_OBJECTS];
  logic signed [WORD_W-1:0]  mat_q;
  logic signed [WORD_W-1:0]  trn_q;
  logic        [DEPTH_W-1:0] dep_q;

  // Working registers of one transform.
  logic signed [WORD_W-1:0]  v   [3];
  logic signed [WORD_W-1:0]  r   [2];
  logic        [OBJ_W-1:0]   cur;
  logic        [OBJ_W-1:0]   scan;
  logic        [DEPTH_W-1:0] dcur;
  logic        [1:0]         row;
  logic        [1:0]         col;
  logic                      missing;

  logic                      accept;
  logic                      obj_ok;
  logic                      out_free;
  logic        [MAT_AW-1:0]  mat_waddr;
  logic        [MAT_AW-1:0]  mat_raddr;
  logic        [TRN_AW-1:0]  trn_waddr;
  logic        [TRN_AW-1:0]  trn_raddr;
  logic        [DEP_AW-1:0]  dep_raddr;
  logic        [3:0]         elem;
  logic signed [WORD_W-1:0]  operand;
  logic signed [WORD_W-1:0]  row_sum;
  logic signed [ACC_W-1:0]   acc;
  mac_ctl_t                  mac_ctl;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign obj_ok   = 32'(object_index) < MAX_OBJECTS;

  // Addresses: object times nine plus element, object times three plus row.
  always_comb begin
    elem      = {row, 1'b0} + {2'b00, row} + {2'b00, col};
    mat_waddr = (MAT_AW'(object_index) << 3) + MAT_AW'(object_index) + MAT_AW'(word_select);
    trn_waddr = (TRN_AW'(object_index) << 1) + TRN_AW'(object_index)
              + TRN_AW'(word_select - SEL_TRN_X);
    mat_raddr = (MAT_AW'(cur) << 3) + MAT_AW'(cur) + MAT_AW'(elem);
    trn_raddr = (TRN_AW'(cur) << 1) + TRN_AW'(cur) + TRN_AW'(row);
    if (state == S_SREAD) begin
      dep_raddr = DEP_AW'(scan - OBJ_W'(1));
    end else begin
      dep_raddr = DEP_AW'(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE && obj_ok && word_select < SEL_TRN_X) begin
      mat_mem[mat_waddr] <= word_value;
    end
    mat_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE && obj_ok && word_select >= SEL_TRN_X
        && word_select < SEL_DEPTH) begin
      trn_mem[trn_waddr] <= word_value;
    end
    trn_q <= trn_mem[trn_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE && obj_ok && word_select == SEL_DEPTH) begin
      dep_mem[DEP_AW'(object_index)] <= word_value[DEPTH_W-1:0];
    end
    dep_q <= dep_mem[dep_raddr];
  end

  // Column operand for the shared multiplier.
  always_comb begin
    case (col)
      2'd0:    operand = v[0];
      2'd1:    operand = v[1];
      2'd2:    operand = v[2];
      default: operand = v[0];
    endcase
  end

  always_comb begin
    mac_ctl.mul = (state == S_MUL);
    mac_ctl.acc = (state == S_ACC);
    mac_ctl.clr = (col == 2'd0);
  end

  hvt_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (operand),
    .op_b (mat_q),
    .acc  (acc)
  );

  // The row sum and the translation add both wrap to 16 bits.
  assign row_sum = acc[WORD_W-1:0] + trn_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded below whenever it frees up.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && kind == KIND_TRANSFORM) begin
            v[0]    <= vertex_x;
            v[1]    <= vertex_y;
            v[2]    <= vertex_z;
            cur     <= object_index;
            row     <= 2'd0;
            col     <= 2'd0;
            missing <= !obj_ok;
            state   <= obj_ok ? S_MWAIT : S_DONE;
          end
        end
        S_MWAIT: state <= S_MUL;
        S_MUL:   state <= S_ACC;
        S_ACC: begin
          if (col == 2'd2) begin
            state <= S_ROW;
          end else begin
            col   <= col + 2'd1;
            state <= S_MWAIT;
          end
        end
        S_ROW: begin
          col <= 2'd0;
          if (row == 2'd2) begin
            // Level finished: the new vertex replaces the old one.
            v[0]  <= r[0];
            v[1]  <= r[1];
            v[2]  <= row_sum;
            row   <= 2'd0;
            state <= S_DREAD;
          end else begin
            r[row[0]] <= row_sum;
            row       <= row + 2'd1;
            state     <= S_MWAIT;
          end
        end
        S_DREAD: state <= S_DCHK;
        S_DCHK: begin
          dcur <= dep_q;
          scan <= cur;
          if (dep_q == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_SREAD;
          end
        end
        S_SREAD: begin
          if (scan == '0) begin
            missing <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          // Exact compare one bit wider, so depth 31 never matches.
          if ({1'b0, dep_q} + 6'd1 == {1'b0, dcur}) begin
            cur   <= scan - OBJ_W'(1);
            state <= S_MWAIT;
          end else begin
            scan  <= scan - OBJ_W'(1);
            state <= S_SREAD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_x          <= missing ? '0 : v[0];
            out_y          <= missing ? '0 : v[1];
            out_z          <= missing ? '0 : v[2];
            parent_missing <= missing;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/hvt_mac.sv */
// Shared multiply / scale / accumulate unit of the vertex transform core.
// Depends on hvt_pkg.
`default_nettype none

module hvt_mac
  import hvt_pkg::*;
(
  input  wire                      clk,
  input  mac_ctl_t                 ctl,
  input  wire signed [WORD_W-1:0]  op_a,
  input  wire signed [WORD_W-1:0]  op_b,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [QUOT_W-1:0] quot;
  logic signed [ACC_W-1:0]  acc_next;

  // Division by 4096 rounding toward zero: bias negative products first.
  always_comb begin
    prod_adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
    quot     = prod_adj[PROD_W-1:FRAC_BITS];
    acc_next = (ctl.clr ? ACC_W'(0) : acc) + ACC_W'(quot);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= op_a * op_b;
    end
    if (ctl.acc) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire
